[rtl/dcm_attitude_propagation_macros.svh]
// assertion helpers for the rtl
`ifndef DCM_ATTITUDE_PROPAGATION_MACROS_SVH
`define DCM_ATTITUDE_PROPAGATION_MACROS_SVH

// same-cycle implication
`define DCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dcm_pkg.sv]
package dcm_pkg;

  localparam int ELEM_W     = 32;
  localparam int FRAC_B     = ELEM_W - 2;
  localparam int WORD_W     = 64;
  localparam int MEM_DEPTH  = 32;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int MAT_N      = 9;
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 296;
  localparam int SH_W       = 6;

  localparam logic [ADDR_W-1:0] A_RATE = ADDR_W'(9);
  localparam logic [ADDR_W-1:0] A_ERR  = ADDR_W'(18);
  localparam logic [ADDR_W-1:0] A_X    = ADDR_W'(19);
  localparam logic [ADDR_W-1:0] A_Y    = ADDR_W'(22);
  localparam logic [ADDR_W-1:0] A_SC   = ADDR_W'(28);

  localparam logic signed [WORD_W-1:0] LIMIT    = 64'sd1 <<< 62;
  localparam logic signed [WORD_W-1:0] ONE_EL   = 64'sd1 <<< FRAC_B;
  localparam logic signed [WORD_W-1:0] THREE_EL = 64'sd3 <<< FRAC_B;
  localparam logic signed [WORD_W-1:0] EL_MAX   = (64'sd1 <<< (ELEM_W - 1)) - 64'sd1;
  localparam logic signed [WORD_W-1:0] EL_MIN   = -(64'sd1 <<< (ELEM_W - 1));

  localparam logic [SH_W-1:0] SH_RATE = SH_W'(24);
  localparam logic [SH_W-1:0] SH_EL   = SH_W'(FRAC_B);
  localparam logic [SH_W-1:0] SH_HALF = SH_W'(FRAC_B + 1);
  localparam logic [SH_W-1:0] SH_DT   = SH_W'(32);

  localparam logic REG_STEP_TIME  = 1'b0;
  localparam logic REG_RATE_FRAME = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_OPER, S_MULW, S_LOADROW, S_WAIT_OUT, S_READ
  } state_t;

  typedef enum logic [2:0] {
    PH_RATE, PH_INTEG, PH_ERR, PH_XY, PH_Z, PH_SC, PH_FIN
  } phase_t;

  typedef enum logic [1:0] {K_LOAD, K_MAC, K_STORE} kind_t;
  typedef enum logic [2:0] {SRC_ZERO, SRC_MEM, SRC_P, SRC_Q, SRC_R, SRC_DT} src_t;
  typedef enum logic [1:0] {ST_PLAIN, ST_SAT, ST_THREE} store_t;

  typedef struct packed {
    kind_t             kind;
    src_t              src_a;
    src_t              src_b;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] dest;
    logic              neg;
    logic [SH_W-1:0]   shift;
    store_t            mode;
  } uop_t;

  typedef struct packed {
    logic            start;
    logic [SH_W-1:0] shift;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  function automatic logic signed [WORD_W-1:0] clamp62(logic signed [WORD_W:0] v);
    if (v > (WORD_W+1)'(LIMIT)) return LIMIT;
    if (v < -((WORD_W+1)'(LIMIT))) return -LIMIT;
    return v[WORD_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] ident_el(logic [ADDR_W-1:0] a);
    if (a == ADDR_W'(0) || a == ADDR_W'(4) || a == ADDR_W'(8)) return ONE_EL;
    return '0;
  endfunction

  function automatic logic [1:0] div3(logic [3:0] v);
    if (v >= 4'd6) return 2'd2;
    if (v >= 4'd3) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic [ADDR_W-1:0] x3(logic [ADDR_W-1:0] v);
    return ADDR_W'({v, 1'b0} + v);
  endfunction

  function automatic logic [3:0] idx_last(phase_t ph);
    unique case (ph)
      PH_ERR:       return 4'd0;
      PH_XY:        return 4'd5;
      PH_Z, PH_SC:  return 4'd2;
      default:      return 4'd8;
    endcase
  endfunction

  function automatic logic [2:0] sub_last(phase_t ph);
    unique case (ph)
      PH_RATE, PH_Z:  return 3'd3;
      PH_ERR, PH_SC:  return 3'd4;
      default:        return 3'd2;
    endcase
  endfunction

  function automatic uop_t get_uop(phase_t ph, logic [3:0] idx, logic [2:0] sub,
                                   logic frame);
    uop_t              u;
    logic [1:0]        row;
    logic [1:0]        col;
    logic [1:0]        sel;
    logic [1:0]        k;
    logic [1:0]        c1;
    logic [1:0]        c2;
    logic [ADDR_W-1:0] i5;
    logic [ADDR_W-1:0] r5;
    logic [ADDR_W-1:0] c5;
    logic [ADDR_W-1:0] s5;
    u = '0;
    row = div3(idx);
    col = 2'(idx - 4'({row, 1'b0}) - 4'(row));
    i5 = ADDR_W'(idx);
    r5 = ADDR_W'(row);
    c5 = ADDR_W'(col);
    s5 = ADDR_W'(sub - 3'd1);
    k = 2'd0;
    c1 = 2'd1;
    c2 = 2'd2;
    u.kind = K_LOAD;
    u.src_a = SRC_ZERO;
    u.src_b = SRC_MEM;
    u.shift = SH_EL;
    u.mode = ST_PLAIN;
    unique case (ph)
      PH_RATE: begin
        sel = frame ? col : row;
        if (sub == 3'd3) begin
          u.kind = K_STORE;
          u.dest = A_RATE + i5;
        end else if (sub != 3'd0) begin
          u.kind = K_MAC;
          u.shift = SH_RATE;
          unique case (sel)
            2'd0: begin
              if (sub == 3'd1) begin
                u.src_a = SRC_R; k = 2'd1; u.neg = 1'b0;
              end else begin
                u.src_a = SRC_Q; k = 2'd2; u.neg = 1'b1;
              end
            end
            2'd1: begin
              if (sub == 3'd1) begin
                u.src_a = SRC_R; k = 2'd0; u.neg = 1'b1;
              end else begin
                u.src_a = SRC_P; k = 2'd2; u.neg = 1'b0;
              end
            end
            default: begin
              if (sub == 3'd1) begin
                u.src_a = SRC_Q; k = 2'd0; u.neg = 1'b0;
              end else begin
                u.src_a = SRC_P; k = 2'd1; u.neg = 1'b1;
              end
            end
          endcase
          u.addr_b = frame ? (x3(r5) + ADDR_W'(k)) : (x3(ADDR_W'(k)) + c5);
        end
      end
      PH_INTEG: begin
        if (sub == 3'd0) begin
          u.src_a = SRC_MEM;
          u.addr_a = i5;
        end else if (sub == 3'd1) begin
          u.kind = K_MAC;
          u.src_a = SRC_MEM;
          u.addr_a = A_RATE + i5;
          u.src_b = SRC_DT;
          u.shift = SH_DT;
        end else begin
          u.kind = K_STORE;
          u.mode = ST_SAT;
          u.dest = i5;
        end
      end
      PH_ERR: begin
        if (sub == 3'd4) begin
          u.kind = K_STORE;
          u.dest = A_ERR;
        end else if (sub != 3'd0) begin
          u.kind = K_MAC;
          u.src_a = SRC_MEM;
          u.addr_a = s5;
          u.addr_b = ADDR_W'(3) + s5;
        end
      end
      PH_XY: begin
        if (sub == 3'd0) begin
          u.src_a = SRC_MEM;
          u.addr_a = x3(r5) + c5;
        end else if (sub == 3'd1) begin
          u.kind = K_MAC;
          u.src_a = SRC_MEM;
          u.addr_a = A_ERR;
          u.addr_b = (row != 2'd0) ? c5 : (ADDR_W'(3) + c5);
          u.neg = 1'b1;
          u.shift = SH_HALF;
        end else begin
          u.kind = K_STORE;
          u.dest = A_X + i5;
        end
      end
      PH_Z: begin
        unique case (col)
          2'd0:    begin c1 = 2'd1; c2 = 2'd2; end
          2'd1:    begin c1 = 2'd2; c2 = 2'd0; end
          default: begin c1 = 2'd0; c2 = 2'd1; end
        endcase
        if (sub == 3'd3) begin
          u.kind = K_STORE;
          u.dest = A_Y + ADDR_W'(3) + i5;
        end else if (sub != 3'd0) begin
          u.kind = K_MAC;
          u.src_a = SRC_MEM;
          u.neg = (sub == 3'd2);
          u.addr_a = A_X + ADDR_W'((sub == 3'd1) ? c1 : c2);
          u.addr_b = A_Y + ADDR_W'((sub == 3'd1) ? c2 : c1);
        end
      end
      PH_SC: begin
        if (sub == 3'd4) begin
          u.kind = K_STORE;
          u.mode = ST_THREE;
          u.dest = A_SC + i5;
        end else if (sub != 3'd0) begin
          u.kind = K_MAC;
          u.src_a = SRC_MEM;
          u.addr_a = A_X + x3(i5) + s5;
          u.addr_b = A_X + x3(i5) + s5;
        end
      end
      default: begin
        if (sub == 3'd1) begin
          u.kind = K_MAC;
          u.src_a = SRC_MEM;
          u.addr_a = A_SC + r5;
          u.addr_b = A_X + x3(r5) + c5;
          u.shift = SH_HALF;
        end else if (sub == 3'd2) begin
          u.kind = K_STORE;
          u.mode = ST_SAT;
          u.dest = i5;
        end
      end
    endcase
    return u;
  endfunction

endpackage

[rtl/dcm_mul.sv]
module dcm_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dcm_pkg::mul_req_t                      req,
  input  logic signed [dcm_pkg::WORD_W-1:0]      a,
  input  logic signed [dcm_pkg::WORD_W-1:0]      b,
  output dcm_pkg::mul_stat_t                     stat,
  output logic signed [dcm_pkg::WORD_W-1:0]      result
);

  logic                          busy;
  logic                          done;
  logic [2:0]                    cnt;
  logic                          neg;
  logic [62:0]                   ua;
  logic [62:0]                   ub;
  logic [dcm_pkg::SH_W-1:0]      shift;
  logic [63:0]                   pp;
  logic [1:0]                    pp_sel;
  logic [127:0]                  acc;

  logic signed [dcm_pkg::WORD_W-1:0] abs_a;
  logic signed [dcm_pkg::WORD_W-1:0] abs_b;
  logic [31:0]                   op_x;
  logic [31:0]                   op_y;
  logic [127:0]                  pp_wide;
  logic [127:0]                  rsum;
  logic [127:0]                  shifted;
  logic [63:0]                   mag;

  assign abs_a = a[63] ? -a : a;
  assign abs_b = b[63] ? -b : b;
  assign op_x = cnt[1] ? {1'b0, ua[62:32]} : ua[31:0];
  assign op_y = cnt[0] ? {1'b0, ub[62:32]} : ub[31:0];

  always_comb begin
    unique case (pp_sel)
      2'd0:    pp_wide = {64'd0, pp};
      2'd3:    pp_wide = {pp, 64'd0};
      default: pp_wide = {32'd0, pp, 32'd0};
    endcase
  end

  assign rsum = acc + (128'd1 << (shift - dcm_pkg::SH_W'(1)));
  assign shifted = rsum >> shift;
  assign mag = (shifted > 128'(dcm_pkg::LIMIT)) ? 64'(dcm_pkg::LIMIT) : shifted[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg   <= a[63] ^ b[63];
      ua    <= abs_a[62:0];
      ub    <= abs_b[62:0];
      shift <= req.shift;
      acc   <= '0;
    end else if (busy) begin
      if (cnt <= 3'd3) begin
        pp     <= op_x * op_y;
        pp_sel <= cnt[1:0];
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + pp_wide;
      end
      if (cnt == 3'd5) begin
        result <= neg ? -$signed(mag) : $signed(mag);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[rtl/dcm_attitude_propagation.sv]
// channel   dir   tdata (low bit up)                                   tuser
// s_*       in    rate_p, rate_q, rate_r, row_select, load_first,       cmd
//                 load_second, load_third (200 bits, zero fill)
// m_*       out   out_r1c1 .. out_r3c3, saturated (296 bits, zero fill)  -
// cfg_*     in    index 0 step_time, index 1 rate_frame
//
// propagate time is set by the shared 4-phase multiplier (about 60 products)
// and one memory access per micro-op
// one transaction at a time; the next input is taken while a result waits
// reset: matrix reads as identity through per-entry valid bits, no clearing pass
// a held output stalls only the final readout of the following transaction
`include "dcm_attitude_propagation_macros.svh"

module dcm_attitude_propagation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // rate_p, rate_q, rate_r, row_select, load_first, load_second, load_third
  input  logic [dcm_pkg::IN_DATA_W-1:0]       s_tdata,
  // cmd
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_r1c1 .. out_r3c3, saturated
  output logic [dcm_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                cfg_write,
  input  logic [0:0]                          cfg_index,
  input  logic [31:0]                         cfg_data
);

  dcm_pkg::state_t   state;
  dcm_pkg::state_t   state_next;
  dcm_pkg::phase_t   ph;
  logic [3:0]        idx;
  logic [2:0]        sub;
  logic signed [dcm_pkg::WORD_W-1:0] acc;
  logic              flag;
  logic signed [31:0] rate_p;
  logic signed [31:0] rate_q;
  logic signed [31:0] rate_r;
  logic [1:0]        row_sel;
  logic signed [31:0] load_el [3];
  logic [31:0]       step_time;
  logic              rate_frame;
  logic signed [dcm_pkg::WORD_W-1:0] mem [dcm_pkg::MEM_DEPTH];
  logic [dcm_pkg::MAT_N-1:0] valid;
  logic signed [dcm_pkg::WORD_W-1:0] rd0;
  logic signed [dcm_pkg::WORD_W-1:0] rd1;
  logic [31:0]       out_mat [dcm_pkg::MAT_N];
  logic              out_sat;

  dcm_pkg::uop_t     uop;
  dcm_pkg::mul_req_t mul_req;
  dcm_pkg::mul_stat_t mul_stat;
  logic signed [dcm_pkg::WORD_W-1:0] mul_res;
  logic signed [dcm_pkg::WORD_W-1:0] opa;
  logic signed [dcm_pkg::WORD_W-1:0] opb;
  logic signed [dcm_pkg::WORD_W-1:0] acc_mac;
  logic signed [dcm_pkg::WORD_W-1:0] store_val;
  logic              store_clip;
  logic              last_sub;
  logic              last_idx;
  logic              fin;
  logic              mem_we;
  logic [dcm_pkg::ADDR_W-1:0] waddr;
  logic signed [dcm_pkg::WORD_W-1:0] wdata;
  logic [dcm_pkg::ADDR_W-1:0] raddr0;
  logic [dcm_pkg::ADDR_W-1:0] raddr1;

  dcm_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .a      (opa),
    .b      (opb),
    .stat   (mul_stat),
    .result (mul_res)
  );

  assign uop = dcm_pkg::get_uop(ph, idx, sub, rate_frame);
  assign last_sub = (sub == dcm_pkg::sub_last(ph));
  assign last_idx = (idx == dcm_pkg::idx_last(ph));
  assign fin = last_sub && last_idx && (ph == dcm_pkg::PH_FIN);

  always_comb begin
    unique case (uop.src_a)
      dcm_pkg::SRC_MEM: opa = rd0;
      dcm_pkg::SRC_P:   opa = 64'(rate_p);
      dcm_pkg::SRC_Q:   opa = 64'(rate_q);
      dcm_pkg::SRC_R:   opa = 64'(rate_r);
      dcm_pkg::SRC_DT:  opa = $signed({32'd0, step_time});
      default:          opa = '0;
    endcase
    opb = (uop.src_b == dcm_pkg::SRC_DT) ? $signed({32'd0, step_time}) : rd1;
  end

  assign acc_mac = dcm_pkg::clamp62(uop.neg ? (65'(acc) - 65'(mul_res))
                                            : (65'(acc) + 65'(mul_res)));

  always_comb begin
    store_clip = 1'b0;
    unique case (uop.mode)
      dcm_pkg::ST_SAT: begin
        if (acc > dcm_pkg::EL_MAX) begin
          store_val = dcm_pkg::EL_MAX;
          store_clip = 1'b1;
        end else if (acc < dcm_pkg::EL_MIN) begin
          store_val = dcm_pkg::EL_MIN;
          store_clip = 1'b1;
        end else begin
          store_val = acc;
        end
      end
      dcm_pkg::ST_THREE: store_val = dcm_pkg::clamp62(65'(dcm_pkg::THREE_EL) - 65'(acc));
      default:           store_val = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    waddr = uop.dest;
    wdata = store_val;
    raddr0 = uop.addr_a;
    raddr1 = uop.addr_b;
    mul_req.start = 1'b0;
    mul_req.shift = uop.shift;
    s_tready = 1'b0;
    unique case (state)
      dcm_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = s_tuser[0] ? dcm_pkg::S_LOADROW : dcm_pkg::S_ISSUE;
        end
      end
      dcm_pkg::S_ISSUE: begin
        if (uop.kind == dcm_pkg::K_STORE) begin
          mem_we = 1'b1;
          if (fin) state_next = dcm_pkg::S_WAIT_OUT;
        end else begin
          state_next = dcm_pkg::S_OPER;
        end
      end
      dcm_pkg::S_OPER: begin
        if (uop.kind == dcm_pkg::K_MAC) begin
          mul_req.start = 1'b1;
          state_next = dcm_pkg::S_MULW;
        end else begin
          state_next = dcm_pkg::S_ISSUE;
        end
      end
      dcm_pkg::S_MULW: begin
        if (mul_stat.done) state_next = dcm_pkg::S_ISSUE;
      end
      dcm_pkg::S_LOADROW: begin
        mem_we = (row_sel != 2'd3);
        waddr = dcm_pkg::ADDR_W'({row_sel, 1'b0} + row_sel + idx);
        wdata = 64'(load_el[idx[1:0]]);
        if (idx == 4'd2) state_next = dcm_pkg::S_WAIT_OUT;
      end
      dcm_pkg::S_WAIT_OUT: begin
        if (!m_tvalid) state_next = dcm_pkg::S_READ;
      end
      dcm_pkg::S_READ: begin
        raddr0 = dcm_pkg::ADDR_W'(idx);
        if (idx == 4'd9) state_next = dcm_pkg::S_IDLE;
      end
      default: state_next = dcm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= 32'd42949673;
      rate_frame <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index[0])
        dcm_pkg::REG_STEP_TIME:  step_time <= cfg_data;
        dcm_pkg::REG_RATE_FRAME: rate_frame <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we && waddr < dcm_pkg::ADDR_W'(dcm_pkg::MAT_N)) begin
      valid[waddr[3:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (raddr0 < dcm_pkg::ADDR_W'(dcm_pkg::MAT_N) && !valid[raddr0[3:0]]) begin
      rd0 <= dcm_pkg::ident_el(raddr0);
    end else begin
      rd0 <= mem[raddr0];
    end
    if (raddr1 < dcm_pkg::ADDR_W'(dcm_pkg::MAT_N) && !valid[raddr1[3:0]]) begin
      rd1 <= dcm_pkg::ident_el(raddr1);
    end else begin
      rd1 <= mem[raddr1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= dcm_pkg::PH_RATE;
      idx <= '0;
      sub <= '0;
      flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        dcm_pkg::S_IDLE: begin
          if (s_tvalid) begin
            flag <= 1'b0;
            ph <= dcm_pkg::PH_RATE;
            idx <= '0;
            sub <= '0;
          end
        end
        dcm_pkg::S_ISSUE, dcm_pkg::S_OPER, dcm_pkg::S_MULW: begin
          if ((state == dcm_pkg::S_ISSUE && uop.kind == dcm_pkg::K_STORE) ||
              (state == dcm_pkg::S_OPER && uop.kind == dcm_pkg::K_LOAD) ||
              (state == dcm_pkg::S_MULW && mul_stat.done)) begin
            if (state == dcm_pkg::S_ISSUE && store_clip) flag <= 1'b1;
            if (last_sub) begin
              sub <= '0;
              if (last_idx) begin
                idx <= '0;
                if (ph != dcm_pkg::PH_FIN) ph <= dcm_pkg::phase_t'(ph + 3'd1);
              end else begin
                idx <= idx + 4'd1;
              end
            end else begin
              sub <= sub + 3'd1;
            end
          end
        end
        dcm_pkg::S_LOADROW: idx <= (idx == 4'd2) ? 4'd0 : idx + 4'd1;
        dcm_pkg::S_WAIT_OUT: idx <= '0;
        dcm_pkg::S_READ: begin
          idx <= idx + 4'd1;
          if (idx == 4'd9) m_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == dcm_pkg::S_IDLE && s_tvalid) begin
      rate_p <= s_tdata[31:0];
      rate_q <= s_tdata[63:32];
      rate_r <= s_tdata[95:64];
      row_sel <= s_tdata[97:96];
      load_el[0] <= s_tdata[129:98];
      load_el[1] <= s_tdata[161:130];
      load_el[2] <= s_tdata[193:162];
    end
    if (state == dcm_pkg::S_OPER && uop.kind == dcm_pkg::K_LOAD) acc <= opa;
    if (state == dcm_pkg::S_MULW && mul_stat.done) acc <= acc_mac;
    if (state == dcm_pkg::S_READ && idx != 4'd0) begin
      out_mat[idx - 4'd1] <= rd0[31:0];
      if (idx == 4'd9) out_sat <= flag;
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int n = 0; n < dcm_pkg::MAT_N; n++) begin
      m_tdata[n*32 +: 32] = out_mat[n];
    end
    m_tdata[dcm_pkg::MAT_N*32] = out_sat;
  end

  `DCM_ASSERT_NOW(a_mul_free, mul_req.start, !mul_stat.busy, "multiplier started while busy")
  `DCM_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state != dcm_pkg::S_IDLE, "accept left block idle")
  `DCM_ASSERT_NOW(a_write_src, mem_we, state == dcm_pkg::S_ISSUE || state == dcm_pkg::S_LOADROW, "stray memory write")
  `DCM_ASSERT_NOW(a_out_from_read, $rose(m_tvalid), $past(state) == dcm_pkg::S_READ, "result raised outside readout")

endmodule
